### hw/rtl/itoa_pkg.sv
// shared types, constants and helpers for the integer to ascii formatter
// used by every module of the block, no dependencies

package itoa_pkg;

    localparam int BIN_W = 32;
    localparam int DIG_N = 10;
    localparam int BCD_W = 4 * DIG_N;
    localparam int CNT_W = $clog2(BIN_W);
    localparam int IDX_W = $clog2(DIG_N);
    localparam int CHR_W = 7;

    localparam logic [CHR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHR_W-1:0] CHAR_A     = 7'h41;

    localparam logic [1:0] FUNC_SIGNED = 2'd1;

    typedef struct packed {
        logic             hex;
        logic             neg;
        logic [BCD_W-1:0] digits;
    } itoa_cmd_t;

    function automatic logic [CHR_W-1:0] itoa_ascii(input logic [3:0] d);
        logic [CHR_W-1:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {3'b000, d};
        end else begin
            r = CHAR_A + {3'b000, d} - 7'd10;
        end
        return r;
    endfunction

endpackage

### hw/rtl/itoa_bcd.sv
// bit-serial binary to bcd converter, one input bit per cycle (shift and add 3)
// depends on itoa_pkg

module itoa_bcd (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic [itoa_pkg::BIN_W-1:0]    bin,
    output logic                          done,
    output logic [itoa_pkg::BCD_W-1:0]    bcd
);
    import itoa_pkg::*;

    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [BCD_W-1:0] corr;

    always_comb begin
        for (int i = 0; i < DIG_N; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                corr[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                corr[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load) begin
            bin_next = bin;
            bcd_next = '0;
            cnt_next = CNT_W'(BIN_W - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            bcd_next = {corr[BCD_W-2:0], bin_reg[BIN_W-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### hw/rtl/itoa_emit.sv
// character sequencer: prefix, then one digit per cycle unless the output stalls, with leading zero skip
// drives the registered output channel; depends on itoa_pkg

module itoa_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  itoa_pkg::itoa_cmd_t           cmd,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // character[6:0], zero pad
    output logic                          m_tlast
);
    import itoa_pkg::*;

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_PRE0  = 5'b00010,
        E_PREX  = 5'b00100,
        E_MINUS = 5'b01000,
        E_DIG   = 5'b10000
    } emit_state_t;

    emit_state_t      state_reg, state_next;
    logic [BCD_W-1:0] dig_reg, dig_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             started_reg, started_next;
    logic             valid_reg, valid_next;
    logic [CHR_W-1:0] char_reg, char_next;
    logic             last_reg, last_next;
    logic             can;
    logic [3:0]       top_dig;

    assign can     = !valid_reg || m_tready;
    assign top_dig = dig_reg[BCD_W-1 -: 4];

    always_comb begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        valid_next   = valid_reg && !m_tready;
        unique case (state_reg)
            E_IDLE: begin
                if (start) begin
                    dig_next     = cmd.digits;
                    idx_next     = IDX_W'(DIG_N - 1);
                    started_next = 1'b0;
                    if (cmd.hex) begin
                        state_next = E_PRE0;
                    end else if (cmd.neg) begin
                        state_next = E_MINUS;
                    end else begin
                        state_next = E_DIG;
                    end
                end
            end
            E_PRE0: begin
                if (can) begin
                    char_next  = CHAR_ZERO;
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = E_PREX;
                end
            end
            E_PREX: begin
                if (can) begin
                    char_next  = CHAR_X;
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = E_DIG;
                end
            end
            E_MINUS: begin
                if (can) begin
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = E_DIG;
                end
            end
            E_DIG: begin
                if (!started_reg && top_dig == 4'd0 && idx_reg != '0) begin
                    // leading zero
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    idx_next = idx_reg - 1'b1;
                end else if (can) begin
                    char_next    = itoa_ascii(top_dig);
                    last_next    = (idx_reg == '0);
                    valid_next   = 1'b1;
                    started_next = 1'b1;
                    dig_next     = {dig_reg[BCD_W-5:0], 4'd0};
                    idx_next     = idx_reg - 1'b1;
                    if (idx_reg == '0) begin
                        state_next = E_IDLE;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            started_reg <= started_next;
            idx_reg     <= idx_next;
        end
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy     = (state_reg != E_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// integer to ascii formatter: a decimal item passes through accept, the bcd converter, emitter
// start, a minus sign (negative only), the digit scan and hand-back; a hex item passes through
// accept, the prefix, the digit scan and hand-back; output stalls lengthen an item; the first
// character follows the converter finishing (hex: the accept), later for each suppressed leading
// zero; one item at a time; aresetn (synchronous) clears control state
// depends on itoa_pkg, itoa_bcd, itoa_emit

module integer_to_ascii_formatter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [itoa_pkg::BIN_W-1:0]  s_tdata,   // value[31:0]
    input  logic [1:0]                  s_tuser,   // func[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // character[6:0], zero pad
    output logic                        m_tlast
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_CONV = 3'b010,
        T_EMIT = 3'b100
    } top_state_t;

    top_state_t       state_reg, state_next;
    logic             neg_reg, neg_next;
    logic             s_acc;
    logic             in_neg;
    logic [BIN_W-1:0] mag;
    logic             bcd_load;
    logic             bcd_done;
    logic [BCD_W-1:0] bcd;
    logic             emit_start;
    logic             emit_busy;
    itoa_cmd_t        cmd;

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_neg   = (s_tuser == FUNC_SIGNED) && s_tdata[BIN_W-1];
    assign mag      = in_neg ? (BIN_W'(0) - s_tdata) : s_tdata;
    assign bcd_load = s_acc && !s_tuser[1];

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        emit_start = 1'b0;
        cmd.hex    = 1'b0;
        cmd.neg    = neg_reg;
        cmd.digits = bcd;
        unique case (state_reg)
            T_IDLE: begin
                if (s_acc) begin
                    neg_next = in_neg;
                    if (s_tuser[1]) begin
                        emit_start = 1'b1;
                        cmd.hex    = 1'b1;
                        cmd.neg    = 1'b0;
                        cmd.digits = {{(BCD_W-BIN_W){1'b0}}, s_tdata};
                        state_next = T_EMIT;
                    end else begin
                        state_next = T_CONV;
                    end
                end
            end
            T_CONV: begin
                if (bcd_done) begin
                    emit_start = 1'b1;
                    state_next = T_EMIT;
                end
            end
            T_EMIT: begin
                if (!emit_busy) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
        neg_reg <= neg_next;
    end

    itoa_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (bcd_load),
        .bin     (mag),
        .done    (bcd_done),
        .bcd     (bcd)
    );

    itoa_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (emit_start),
        .cmd      (cmd),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### hw/rtl/itoa_checker.sv
// port-level checker for integer_to_ascii_formatter, attached by bind
// depends on itoa_pkg

module itoa_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [itoa_pkg::BIN_W-1:0]  s_tdata,
    input logic [1:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [7:0]                  m_tdata,
    input logic                        m_tlast
);
    import itoa_pkg::*;

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // one number at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // when ready for a new number, only the final character may still wait
    a_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with an unfinished run");

    // characters are 7-bit ascii
    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("character outside ascii range");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

### tb/integer_to_ascii_formatter_test.sv
// testbench for integer_to_ascii_formatter: formats numbers as unsigned, signed and hex text
// predicts each character stream and checks it against the m_ stream, with random idling
// depends on itoa_pkg and the integer_to_ascii_formatter rtl
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
    import itoa_pkg::*;

    localparam logic [1:0] FUNC_UNSIGNED  = 2'd0;
    localparam logic [1:0] FUNC_HEX       = 2'd2;
    localparam logic [1:0] FUNC_HEX_ALIAS = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [CHR_W-1:0] character;
        logic             last;
    } text_char_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [BIN_W-1:0] s_tdata  = '0;
    logic [1:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;

    text_char_t pending_text[$];
    text_char_t head_char;
    int         err_count     = 0;
    int         chars_checked = 0;
    int         numbers_sent  = 0;
    int         per_format[4] = '{0, 0, 0, 0};
    int         idle_cycles   = 0;
    int         stall_left    = 0;
    bit         src_idle_en   = 1'b0;
    bit         snk_idle_en   = 1'b0;

    integer_to_ascii_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // expected text of one number, queued one character per transaction
    function automatic void queue_number_text(input logic [1:0] func, input logic [31:0] value);
        logic [CHR_W-1:0] prefix[$];
        logic [CHR_W-1:0] digits[$];
        logic [31:0]      mag;
        logic [31:0]      radix;
        logic [31:0]      d;
        text_char_t       tc;
        if (func[1]) begin
            prefix.push_back(CHAR_ZERO);
            prefix.push_back(CHAR_X);
            mag   = value;
            radix = 32'd16;
        end else if (func == FUNC_SIGNED && value[31]) begin
            prefix.push_back(CHAR_MINUS);
            mag   = 32'd0 - value;
            radix = 32'd10;
        end else begin
            mag   = value;
            radix = 32'd10;
        end
        do begin
            d = mag % radix;
            if (d < 32'd10) begin
                digits.push_front(CHAR_ZERO + CHR_W'(d));
            end else begin
                digits.push_front(CHAR_A + CHR_W'(d - 32'd10));
            end
            mag = mag / radix;
        end while (mag != 32'd0);
        foreach (digits[i]) prefix.push_back(digits[i]);
        foreach (prefix[i]) begin
            tc.character = prefix[i];
            tc.last      = (i == prefix.size() - 1);
            pending_text.push_back(tc);
        end
    endfunction

    task automatic send_number(input logic [1:0] func, input logic [31:0] value);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        queue_number_text(func, value);
        numbers_sent++;
        per_format[func]++;
    endtask

    task automatic wait_for_text_drain();
        while (pending_text.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int          k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 20);
            1: v = 32'hFFFF_FFFF - $urandom_range(0, 20);
            2: v = 32'd1 << k;
            3: v = (32'd1 << k) - 32'd1;
            4: v = $urandom_range(0, 99999);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_text.size() == 0) begin
                $error("character: no transaction expected, actual 0x%02h last %0b",
                       m_tdata, m_tlast);
                err_count++;
            end else begin
                head_char = pending_text.pop_front();
                chars_checked++;
                if (m_tdata !== {1'b0, head_char.character}) begin
                    $error("character: expected 0x%02h, actual 0x%02h",
                           {1'b0, head_char.character}, m_tdata);
                    err_count++;
                end
                if (m_tlast !== head_char.last) begin
                    $error("last: expected %0b, actual %0b", head_char.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_number(FUNC_UNSIGNED, 32'd0);
        send_number(FUNC_UNSIGNED, 32'd9);
        send_number(FUNC_UNSIGNED, 32'd10);
        send_number(FUNC_UNSIGNED, 32'hFFFF_FFFF);
        send_number(FUNC_SIGNED, 32'd0);
        send_number(FUNC_SIGNED, 32'hFFFF_FFFF);
        send_number(FUNC_SIGNED, 32'h8000_0000);
        send_number(FUNC_SIGNED, 32'h7FFF_FFFF);
        send_number(FUNC_SIGNED, 32'hFFFF_FFF6);
        send_number(FUNC_SIGNED, 32'd123);
        send_number(FUNC_HEX, 32'd0);
        send_number(FUNC_HEX, 32'hFFFF_FFFF);
        send_number(FUNC_HEX, 32'hDEAD_BEEF);
        send_number(FUNC_HEX, 32'h0000_000A);
        send_number(FUNC_HEX, 32'h0000_0010);
        send_number(FUNC_HEX_ALIAS, 32'd0);
        send_number(FUNC_HEX_ALIAS, 32'h1234_ABCD);
        send_number(FUNC_HEX_ALIAS, 32'h8000_0000);
        send_number(FUNC_UNSIGNED, 32'h8000_0000);
        send_number(FUNC_UNSIGNED, 32'd1_000_000_000);
    endtask

    // sender holds off until the formatter has emitted every pending character
    task automatic test_pause_and_resume();
        send_number(FUNC_SIGNED, 32'h8000_0000);
        send_number(FUNC_HEX, 32'h0F0F_0F0F);
        s_tvalid <= 1'b0;
        wait_for_text_drain();
        @(posedge aclk);
        send_number(FUNC_UNSIGNED, 32'd4_294_967_295);
        send_number(FUNC_HEX_ALIAS, 32'h0000_0001);
    endtask

    task automatic test_random_formats();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        repeat (150) send_number(2'($urandom_range(0, 3)), pick_value());
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (36) send_number(2'($urandom_range(0, 3)), pick_value());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_pause_and_resume();
        test_random_formats();
        test_back_to_back();
        s_tvalid <= 1'b0;
        wait_for_text_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d numbers: %0d unsigned, %0d signed, %0d hex, %0d hex via func 3",
                 numbers_sent, per_format[0], per_format[1], per_format[2], per_format[3]);
        $display("%0d characters checked across idle, stall and back-to-back phases",
                 chars_checked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
